@@ src/scf_pkg.sv @@
package scf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int BANKS      = 4;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SLOT_W     = $clog2(BANKS);
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int MODE_W     = 3;
    localparam int PEND_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd480;

    // floor(x/18) and floor(x/50) by reciprocal, exact over the numerator range
    localparam logic [31:0] RECIP_BOX3 = 32'd3641;
    localparam int          SHIFT_BOX3 = 16;
    localparam logic [31:0] RECIP_BOX5 = 32'd20972;
    localparam int          SHIFT_BOX5 = 20;

    typedef enum logic [MODE_W-1:0] {
        MODE_BOX3,
        MODE_BIN3,
        MODE_BOX5,
        MODE_BIN5,
        MODE_LAPLACE,
        MODE_SHARP5,
        MODE_SHARP6,
        MODE_BYPASS
    } filter_mode_t;

    typedef logic [7:0] pixel_t;
    typedef pixel_t [4:0] column_t;

    typedef struct packed {
        logic [9:0]  s3;
        logic [9:0]  w3;
        logic [10:0] s5;
        logic [11:0] w5;
        pixel_t      r1;
        pixel_t      r2;
        pixel_t      r3;
    } colsum_t;

    typedef struct packed {
        pixel_t pixel;
        logic   last;
    } result_t;

endpackage

@@ src/scf_pixel_if.sv @@
interface scf_pixel_if;
    import scf_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel_in;
    logic   flush;

    modport source (output valid, output pixel_in, output flush, input ready);
    modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

@@ src/scf_result_if.sv @@
interface scf_result_if;
    import scf_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel_out;
    logic   frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

@@ src/spatial_convolution_filter.sv @@
// Streaming 3x3 / 5x5 convolution over 8-bit grey pixels in raster order.
// pixels: valid/ready input; each transfer carries pixel_in, or flush=1 which
// carries no pixel and drains one pending result (no result if none pending).
// results: valid/ready output of pixel_out and frame_last (bottom-right pixel).
// cfg_we/cfg_index/cfg_data: write port for mode, width and height; write only
// while the block is idle.
// The result for pixel p is released by the transfer of pixel p+2*width+2 and
// passes through the line banks, window cells, column sums, kernel combine and
// scaling into the output FIFO. One transfer per cycle is accepted while the
// output side keeps up.
// A credit counter bounds results in flight to the 8-entry output FIFO; when
// the receiver stalls, ready drops once 8 results are owed and the pipeline
// never has to stop.
// Reset clears counters, window and FIFO and restores mode box3, 640x480.
// Line banks are not cleared.
module spatial_convolution_filter
    import scf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    scf_pixel_if.sink             pixels,
    scf_result_if.source          results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    filter_mode_t      mode_reg;
    logic [FW_W-1:0]   width_reg;
    logic [FH_W-1:0]   height_reg;

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    logic [FW_W-1:0]   w_eff;
    logic [FH_W-1:0]   h_eff;
    logic [COL_W-1:0]  ic, oc;
    logic [ROW_W-1:0]  ir, orow;
    logic              accept;
    logic [PEND_W-1:0] pend_inc;
    logic [PEND_W-1:0] lag;
    logic              do_shift, do_prod;
    logic [FW_W-1:0]   oc2;
    logic [SLOT_W-1:0] fl_rows;
    logic [COL_W-1:0]  fl_col;
    logic [SLOT_W-1:0] base;
    logic [COL_W-1:0]  rd_col;
    logic [2:0]        radius;
    logic              border, last;
    logic [FW_W-1:0]   ic_inc, oc_inc;
    logic [FH_W-1:0]   ir_inc, or_inc;

    pixel_t            rd_a [BANKS];
    pixel_t            rd_b [BANKS];

    logic              s1_shift_reg, s1_prod_reg;
    logic [SLOT_W-1:0] s1_base_reg, s1_oslot_reg;
    pixel_t            s1_px_reg;
    logic              s1_border_reg, s1_last_reg;

    logic              s2_prod_reg, s2_border_reg, s2_last_reg;
    pixel_t            s2_centre_reg;
    logic              s3_prod_reg, s3_border_reg, s3_last_reg;
    pixel_t            s3_centre_reg;
    logic              s4_prod_reg, s4_border_reg, s4_last_reg;
    pixel_t            s4_centre_reg;
    logic [16:0]       s4_num_reg, num_next;
    logic signed [11:0] s4_lin_reg, lin_next;

    column_t           new_col;
    column_t           cell_col [5];
    colsum_t           cell_sum [5];

    logic [11:0]       box3_s, bin3_s;
    logic [12:0]       box5_s;
    logic [16:0]       bin5_s;
    logic [9:0]        nb;
    pixel_t            ctr;

    logic [31:0]       mul3, mul5;
    logic [16:0]       scaled;
    pixel_t            value;
    result_t           res;

    result_t           fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]  fifo_cnt_reg;
    logic [FIFO_AW:0]  credit_reg;
    logic              push, pop;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_BOX3;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= filter_mode_t'(cfg_data[MODE_W-1:0]);
                CFG_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = FW_W'(1);
        else if (width_reg > FW_W'(MAX_WIDTH))
            w_eff = FW_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = FH_W'(1);
        else if (height_reg > FH_W'(MAX_HEIGHT))
            h_eff = FH_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // position and pending control
    always_comb
    begin
        ic   = ({1'b0, in_col_reg}  >= w_eff) ? '0 : in_col_reg;
        oc   = ({1'b0, out_col_reg} >= w_eff) ? '0 : out_col_reg;
        ir   = ({1'b0, in_row_reg}  >= h_eff) ? '0 : in_row_reg;
        orow = ({1'b0, out_row_reg} >= h_eff) ? '0 : out_row_reg;

        accept   = pixels.valid && pixels.ready;
        pend_inc = (pend_reg == PEND_MAX) ? PEND_MAX : pend_reg + PEND_W'(1);
        lag      = PEND_W'({w_eff, 1'b0}) + PEND_W'(2);

        do_shift = accept && (!pixels.flush || pend_reg != '0);
        do_prod  = accept && (pixels.flush ? (pend_reg != '0) : (pend_inc > lag));

        // flush: two rows down and two columns on from the drained pixel, wrapping into the row below
        oc2 = {1'b0, oc} + FW_W'(2);
        if (w_eff == FW_W'(1))
        begin
            fl_rows = '0;
            fl_col  = '0;
        end
        else if (oc2 >= w_eff)
        begin
            fl_rows = SLOT_W'(3);
            fl_col  = COL_W'(oc2 - w_eff);
        end
        else
        begin
            fl_rows = SLOT_W'(2);
            fl_col  = COL_W'(oc2);
        end

        base   = pixels.flush ? out_slot_reg + fl_rows : in_slot_reg;
        rd_col = pixels.flush ? fl_col : ic;

        radius = (mode_reg == MODE_BOX5 || mode_reg == MODE_BIN5) ? 3'd2 : 3'd1;
        border = (mode_reg == MODE_BYPASS)
              || ({1'b0, orow} < FH_W'(radius))
              || ({1'b0, oc} < FW_W'(radius))
              || ({1'b0, orow} + FH_W'(radius) >= h_eff)
              || ({1'b0, oc} + FW_W'(radius) >= w_eff);
        last   = ({1'b0, orow} == h_eff - FH_W'(1)) && ({1'b0, oc} == w_eff - FW_W'(1));

        ic_inc = {1'b0, ic} + FW_W'(1);
        oc_inc = {1'b0, oc} + FW_W'(1);
        ir_inc = {1'b0, ir} + FH_W'(1);
        or_inc = {1'b0, orow} + FH_W'(1);

        // every transfer keeps the positions wrapped to the current size
        in_col_next   = accept ? ic : in_col_reg;
        in_row_next   = accept ? ir : in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = accept ? oc : out_col_reg;
        out_row_next  = accept ? orow : out_row_reg;
        out_slot_next = out_slot_reg;
        pend_next     = pend_reg;

        if (accept && !pixels.flush)
        begin
            pend_next = do_prod ? pend_inc - PEND_W'(1) : pend_inc;
            if (ic_inc >= w_eff)
            begin
                in_col_next  = '0;
                in_slot_next = in_slot_reg + SLOT_W'(1);
                in_row_next  = (ir_inc >= h_eff) ? '0 : ROW_W'(ir_inc);
            end
            else
            begin
                in_col_next = COL_W'(ic_inc);
                in_row_next = ir;
            end
        end
        else if (do_prod)
        begin
            pend_next = pend_reg - PEND_W'(1);
        end

        if (do_prod)
        begin
            if (oc_inc >= w_eff)
            begin
                out_col_next  = '0;
                out_slot_next = out_slot_reg + SLOT_W'(1);
                out_row_next  = (or_inc >= h_eff) ? '0 : ROW_W'(or_inc);
            end
            else
            begin
                out_col_next = COL_W'(oc_inc);
                out_row_next = orow;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            pend_reg     <= pend_next;
        end
    end

    // line banks
    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        scf_line_bank u_bank (
            .clk     (clk),
            .we      (accept && !pixels.flush && in_slot_reg == SLOT_W'(b)),
            .waddr   (ic),
            .wdata   (pixels.pixel_in),
            .raddr_a (rd_col),
            .raddr_b (oc),
            .rdata_a (rd_a[b]),
            .rdata_b (rd_b[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_shift_reg <= 1'b0;
            s1_prod_reg  <= 1'b0;
            s2_prod_reg  <= 1'b0;
            s3_prod_reg  <= 1'b0;
            s4_prod_reg  <= 1'b0;
        end
        else
        begin
            s1_shift_reg <= do_shift;
            s1_prod_reg  <= do_prod;
            s2_prod_reg  <= s1_prod_reg;
            s3_prod_reg  <= s2_prod_reg;
            s4_prod_reg  <= s3_prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_base_reg   <= base;
        s1_oslot_reg  <= out_slot_reg;
        s1_px_reg     <= pixels.flush ? '0 : pixels.pixel_in;
        s1_border_reg <= border;
        s1_last_reg   <= last;

        s2_border_reg <= s1_border_reg;
        s2_last_reg   <= s1_last_reg;
        s2_centre_reg <= rd_b[s1_oslot_reg];

        s3_border_reg <= s2_border_reg;
        s3_last_reg   <= s2_last_reg;
        s3_centre_reg <= s2_centre_reg;

        s4_border_reg <= s3_border_reg;
        s4_last_reg   <= s3_last_reg;
        s4_centre_reg <= s3_centre_reg;
        s4_num_reg    <= num_next;
        s4_lin_reg    <= lin_next;
    end

    // window: five column cells, newest on the right
    always_comb
    begin
        for (int m = 0; m < 4; m++)
        begin
            new_col[m] = rd_a[SLOT_W'(s1_base_reg + SLOT_W'(m))];
        end
        new_col[4] = s1_px_reg;
    end

    for (genvar k = 0; k < 5; k++)
    begin : g_cell
        scf_column_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (s1_shift_reg),
            .col_in   ((k == 4) ? new_col : cell_col[(k + 1) % 5]),
            .col_out  (cell_col[k]),
            .sums     (cell_sum[k])
        );
    end

    // kernel combine
    always_comb
    begin
        box3_s = 12'(cell_sum[1].s3) + 12'(cell_sum[2].s3) + 12'(cell_sum[3].s3);
        bin3_s = 12'(cell_sum[1].w3) + {1'b0, cell_sum[2].w3, 1'b0} + 12'(cell_sum[3].w3);
        box5_s = 13'(cell_sum[0].s5) + 13'(cell_sum[1].s5) + 13'(cell_sum[2].s5)
               + 13'(cell_sum[3].s5) + 13'(cell_sum[4].s5);
        bin5_s = 17'(cell_sum[0].w5) + {3'b0, cell_sum[1].w5, 2'b0}
               + {3'b0, cell_sum[2].w5, 2'b0} + {4'b0, cell_sum[2].w5, 1'b0}
               + {3'b0, cell_sum[3].w5, 2'b0} + 17'(cell_sum[4].w5);
        ctr    = cell_sum[2].r2;
        nb     = 10'(cell_sum[2].r1) + 10'(cell_sum[2].r3)
               + 10'(cell_sum[1].r2) + 10'(cell_sum[3].r2);

        num_next = '0;
        lin_next = '0;
        case (mode_reg)
            MODE_BOX3:    num_next = 17'({box3_s, 1'b0}) + 17'd9;
            MODE_BIN3:    num_next = 17'(bin3_s) + 17'd8;
            MODE_BOX5:    num_next = 17'({box5_s, 1'b0}) + 17'd25;
            MODE_BIN5:    num_next = bin5_s + 17'd128;
            MODE_LAPLACE: lin_next = $signed({2'b0, nb}) - $signed({2'b0, ctr, 2'b0})
                                   + 12'sd128;
            MODE_SHARP5:  lin_next = $signed({2'b0, ctr, 2'b0}) + $signed({4'b0, ctr})
                                   - $signed({2'b0, nb});
            MODE_SHARP6:  lin_next = $signed({2'b0, ctr, 2'b0}) + $signed({3'b0, ctr, 1'b0})
                                   - $signed({2'b0, nb});
            default:      ;
        endcase
    end

    // scale and clamp
    always_comb
    begin
        mul3 = 32'(s4_num_reg) * RECIP_BOX3;
        mul5 = 32'(s4_num_reg) * RECIP_BOX5;
        case (mode_reg)
            MODE_BOX3: scaled = 17'(mul3 >> SHIFT_BOX3);
            MODE_BIN3: scaled = s4_num_reg >> 4;
            MODE_BOX5: scaled = 17'(mul5 >> SHIFT_BOX5);
            MODE_BIN5: scaled = s4_num_reg >> 8;
            default:   scaled = '0;
        endcase

        case (mode_reg)
            MODE_LAPLACE, MODE_SHARP5, MODE_SHARP6:
            begin
                if (s4_lin_reg < 0)
                    value = '0;
                else if (s4_lin_reg > 12'sd255)
                    value = 8'hFF;
                else
                    value = s4_lin_reg[7:0];
            end
            default:
            begin
                value = (scaled > 17'd255) ? 8'hFF : scaled[7:0];
            end
        endcase

        res.pixel = s4_border_reg ? s4_centre_reg : value;
        res.last  = s4_last_reg;
    end

    // output FIFO with credit flow control
    assign push = s4_prod_reg;
    assign pop  = results.valid && results.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            fifo_cnt_reg <= fifo_cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
            credit_reg   <= credit_reg + (FIFO_AW+1)'(do_prod) - (FIFO_AW+1)'(pop);
        end
    end

    assign pixels.ready       = (credit_reg < (FIFO_AW+1)'(FIFO_DEPTH));
    assign results.valid      = (fifo_cnt_reg != '0);
    assign results.pixel_out  = fifo_mem[rd_ptr_reg].pixel;
    assign results.frame_last = fifo_mem[rd_ptr_reg].last;

`ifndef NO_ASSERTIONS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result credit above FIFO depth");

    a_fifo_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= credit_reg)
        else $error("FIFO holds more than owed results");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_cnt_reg < (FIFO_AW+1)'(FIFO_DEPTH) || pop))
        else $error("push into full FIFO");

    a_prod_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pixels.flush && pend_reg == '0) |=> !s1_shift_reg)
        else $error("empty flush shifted the window");
`endif

endmodule

@@ src/scf_line_bank.sv @@
module scf_line_bank
    import scf_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [COL_W-1:0] waddr,
    input  pixel_t           wdata,
    input  logic [COL_W-1:0] raddr_a,
    input  logic [COL_W-1:0] raddr_b,
    output pixel_t           rdata_a,
    output pixel_t           rdata_b
);

    pixel_t mem [MAX_WIDTH];
    pixel_t rdata_a_reg;
    pixel_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ src/scf_column_cell.sv @@
module scf_column_cell
    import scf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift_en,
    input  column_t col_in,
    output column_t col_out,
    output colsum_t sums
);

    column_t col_reg;
    colsum_t sums_reg;
    colsum_t sums_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    always_comb
    begin
        sums_next.s3 = 10'(col_reg[1]) + 10'(col_reg[2]) + 10'(col_reg[3]);
        sums_next.w3 = 10'(col_reg[1]) + {1'b0, col_reg[2], 1'b0} + 10'(col_reg[3]);
        sums_next.s5 = 11'(col_reg[0]) + 11'(col_reg[1]) + 11'(col_reg[2])
                     + 11'(col_reg[3]) + 11'(col_reg[4]);
        sums_next.w5 = 12'(col_reg[0]) + {2'b0, col_reg[1], 2'b0}
                     + {2'b0, col_reg[2], 2'b0} + {3'b0, col_reg[2], 1'b0}
                     + {2'b0, col_reg[3], 2'b0} + 12'(col_reg[4]);
        sums_next.r1 = col_reg[1];
        sums_next.r2 = col_reg[2];
        sums_next.r3 = col_reg[3];
    end

    always_ff @(posedge clk)
    begin
        sums_reg <= sums_next;
    end

    assign col_out = col_reg;
    assign sums    = sums_reg;

endmodule
